FILE: src/pinhole_reprojection_residual_macros.svh
// ============================================================================
// Assertion macros for the pinhole reprojection residual block
// Concurrent checks clocked on i_clk and disabled while i_rst_n is low.
// ============================================================================
`ifndef PINHOLE_REPROJECTION_RESIDUAL_MACROS_SVH
`define PINHOLE_REPROJECTION_RESIDUAL_MACROS_SVH

`ifndef ASSERT_OFF

// lbl: label, prop: property that must hold
`define PRR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("assertion failed");

// lbl: label, expr: condition that must never be true
`define PRR_ASSERT_NEVER(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error("forbidden condition");

`else

`define PRR_ASSERT(lbl, prop)
`define PRR_ASSERT_NEVER(lbl, expr)

`endif

`endif

FILE: src/prr_pkg.sv
// ============================================================================
// prr_pkg
// Shared constants, codes and unit request/response types.
// ============================================================================
package prr_pkg;

    localparam int FRAC_BITS_DEF = 16;

    // configuration register reset values
    localparam logic [30:0] FOCAL_X_RST  = 31'd32768000;
    localparam logic [30:0] FOCAL_Y_RST  = 31'd32768000;
    localparam logic [30:0] CENTER_X_RST = 31'd20971520;
    localparam logic [30:0] CENTER_Y_RST = 31'd15728640;
    localparam logic        IDEAL_MODE_RST = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IDEAL_MODE = 3'd4;

    // result word kinds
    localparam logic [2:0] PART_PIXEL   = 3'd0;
    localparam logic [2:0] PART_IDEAL   = 3'd1;
    localparam logic [2:0] PART_JAC_A   = 3'd2;
    localparam logic [2:0] PART_JAC_B   = 3'd3;
    localparam logic [2:0] PART_BEARING = 3'd4;

    // shared unit operations
    localparam logic OP_DIV  = 1'b0;
    localparam logic OP_SQRT = 1'b1;

    localparam logic [31:0] SAT_MAX = 32'h7fff_ffff;
    localparam logic [31:0] SAT_MIN = 32'h8000_0000;

    typedef struct packed {
        logic               start;
        logic               op;
        logic signed [33:0] num;
        logic [31:0]        den;
        logic [63:0]        rad;
    } t_iter_req;

    typedef struct packed {
        logic        done;
        logic        busy;
        logic [31:0] value;
    } t_iter_rsp;

endpackage

FILE: src/prr_if.sv
// ============================================================================
// prr_if
// Handshake channels: observation/pose input, result output, register write.
// ============================================================================
interface prr_obs_if;
    logic               valid;
    logic               ready;
    logic               func;
    logic [3:0]         pose_index;
    logic signed [31:0] pose_value;
    logic [15:0]        lm_ident;
    logic               landmark_found;
    logic signed [31:0] landmark_x;
    logic signed [31:0] landmark_y;
    logic signed [31:0] landmark_z;
    logic signed [31:0] observed_u;
    logic signed [31:0] observed_v;

    modport source (output valid, func, pose_index, pose_value, lm_ident,
                    landmark_found, landmark_x, landmark_y, landmark_z,
                    observed_u, observed_v, input ready);
    modport sink (input valid, func, pose_index, pose_value, lm_ident,
                  landmark_found, landmark_x, landmark_y, landmark_z,
                  observed_u, observed_v, output ready);
endinterface

interface prr_res_if;
    logic               valid;
    logic               ready;
    logic [15:0]        result_landmark;
    logic [2:0]         part;
    logic signed [31:0] value_a;
    logic signed [31:0] value_b;
    logic signed [31:0] value_c;
    logic signed [31:0] value_d;
    logic               last;

    modport source (output valid, result_landmark, part, value_a, value_b,
                    value_c, value_d, last, input ready);
    modport sink (input valid, result_landmark, part, value_a, value_b,
                  value_c, value_d, last, output ready);
endinterface

interface prr_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [prr_pkg::CFG_IDX_W-1:0]    index;
    logic [31:0]                      data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: src/pinhole_reprojection_residual.sv
// ============================================================================
// pinhole_reprojection_residual
// Rotates landmarks into the camera frame, projects and forms residuals.
// ============================================================================
// Use:
//   i_obs  input words. func=0 loads one pose word (rotation slots 0-8,
//          position 9-11) and is absorbed with no result.
//          func=1 is an observation; without landmark_found it is dropped.
//   o_res  result words, one per part: pixel, then (ideal mode) ideal,
//          Jacobian A and B, then bearing with last=1. Depth <= 0 gives none.
//   i_cfg  register writes (focal, center, ideal mode), always ready; write
//          only while no observation is in flight.
// Throughput: one observation at a time; i_obs.ready is low while it runs.
//   Each divide or square root runs in the shared iterative unit (one
//   quotient bit or one root bit per cycle); each multiply has a multiply
//   state and an add state.
// Reset: synchronous, clears pose state to zero and loads register defaults.
// Stall: the output register holds its word until o_res.ready; the
//   sequencer waits at that result until the register is free.
// ============================================================================
`include "pinhole_reprojection_residual_macros.svh"

module pinhole_reprojection_residual #(
    parameter int FRAC_BITS = prr_pkg::FRAC_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    prr_obs_if.sink    i_obs,
    prr_res_if.source  o_res,
    prr_cfg_if.sink    i_cfg
);
    localparam logic signed [65:0] ONE_W  = 66'sd1 <<< FRAC_BITS;
    localparam logic signed [33:0] ONE_N  = 34'sd1 <<< FRAC_BITS;
    localparam logic [63:0]        ONE_SQ = 64'd1 << (2 * FRAC_BITS);
    localparam logic signed [64:0] HALF   = 65'sd1 <<< (FRAC_BITS - 1);

    // sequencer states
    localparam logic [5:0] ST_IDLE   = 6'd0;
    localparam logic [5:0] ST_ROT_M  = 6'd1;
    localparam logic [5:0] ST_ROT_A  = 6'd2;
    localparam logic [5:0] ST_CHK    = 6'd3;
    localparam logic [5:0] ST_DIV_X  = 6'd4;
    localparam logic [5:0] ST_DIV_Y  = 6'd5;
    localparam logic [5:0] ST_UP_M   = 6'd6;
    localparam logic [5:0] ST_UP_A   = 6'd7;
    localparam logic [5:0] ST_VP_M   = 6'd8;
    localparam logic [5:0] ST_VP_A   = 6'd9;
    localparam logic [5:0] ST_OUT0   = 6'd10;
    localparam logic [5:0] ST_DIV_IX = 6'd11;
    localparam logic [5:0] ST_DIV_IY = 6'd12;
    localparam logic [5:0] ST_DIV_ZI = 6'd13;
    localparam logic [5:0] ST_OUT1   = 6'd14;
    localparam logic [5:0] ST_XZ_M   = 6'd15;
    localparam logic [5:0] ST_XZ_A   = 6'd16;
    localparam logic [5:0] ST_YZ_M   = 6'd17;
    localparam logic [5:0] ST_YZ_A   = 6'd18;
    localparam logic [5:0] ST_XY_M   = 6'd19;
    localparam logic [5:0] ST_XY_A   = 6'd20;
    localparam logic [5:0] ST_OUT2   = 6'd21;
    localparam logic [5:0] ST_XX_M   = 6'd22;
    localparam logic [5:0] ST_XX_A   = 6'd23;
    localparam logic [5:0] ST_YY_M   = 6'd24;
    localparam logic [5:0] ST_YY_A   = 6'd25;
    localparam logic [5:0] ST_OUT3   = 6'd26;
    localparam logic [5:0] ST_SX_M   = 6'd27;
    localparam logic [5:0] ST_SX_A   = 6'd28;
    localparam logic [5:0] ST_SY_M   = 6'd29;
    localparam logic [5:0] ST_SY_A   = 6'd30;
    localparam logic [5:0] ST_SQRT   = 6'd31;
    localparam logic [5:0] ST_DIV_BX = 6'd32;
    localparam logic [5:0] ST_DIV_BY = 6'd33;
    localparam logic [5:0] ST_DIV_BZ = 6'd34;
    localparam logic [5:0] ST_OUT4   = 6'd35;

    // saturate a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) begin
            return prr_pkg::SAT_MAX;
        end else if (v < -66'sd2147483648) begin
            return prr_pkg::SAT_MIN;
        end else begin
            return v[31:0];
        end
    endfunction

    // configuration
    logic [30:0] r_fx, r_fy, r_cx, r_cy;
    logic        r_ideal;

    // pose state
    logic signed [31:0] r_rot [9];
    logic signed [31:0] r_pos [3];

    // sequencer and datapath
    logic [5:0]         r_state, n_state;
    logic               r_wait;
    logic [1:0]         r_ri, r_rj;
    logic [15:0]        r_id;
    logic signed [31:0] r_obs_u, r_obs_v;
    logic signed [31:0] r_d [3];
    logic signed [31:0] r_cam [3];
    logic signed [65:0] r_acc;
    logic signed [63:0] r_prod;
    logic signed [31:0] r_x, r_y, r_up, r_vp, r_ix, r_iy, r_zi;
    logic signed [31:0] r_xz, r_yz, r_xy, r_pa, r_pb, r_bx, r_by, r_bz;
    logic [63:0]        r_ss;
    logic [31:0]        r_n;

    // output register
    logic               r_ov, r_olast;
    logic [15:0]        r_olm;
    logic [2:0]         r_opart;
    logic signed [31:0] r_oa, r_ob, r_oc, r_od;

    logic               w_obs_go, w_pose_go, w_ofree, w_ld;
    logic signed [31:0] w_ma, w_mb;
    logic signed [63:0] w_pm;
    logic signed [64:0] w_mw;
    logic signed [65:0] w_acc;
    logic [3:0]         w_ridx;
    logic signed [31:0] w_fx_s, w_fy_s;
    logic signed [31:0] w_la, w_lb, w_lc, w_ld_v;
    logic [2:0]         w_lpart;

    prr_pkg::t_iter_req w_req;
    prr_pkg::t_iter_rsp w_rsp;

    assign i_obs.ready = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_obs_go    = i_obs.valid && i_obs.ready && i_obs.func && i_obs.landmark_found;
    assign w_pose_go   = i_obs.valid && i_obs.ready && !i_obs.func;
    assign w_ofree     = !r_ov || o_res.ready;

    assign w_fx_s = $signed({1'b0, r_fx});
    assign w_fy_s = $signed({1'b0, r_fy});
    assign w_ridx = 4'(r_rj) * 4'd3 + 4'(r_ri);

    // shared multiplier; product registered, consumed in the next state
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_state) inside
            ST_ROT_M: begin
                w_ma = r_rot[w_ridx];
                w_mb = r_d[r_rj];
            end
            ST_UP_M: begin
                w_ma = w_fx_s;
                w_mb = r_x;
            end
            ST_VP_M: begin
                w_ma = w_fy_s;
                w_mb = r_y;
            end
            ST_XZ_M: begin
                w_ma = r_x;
                w_mb = r_zi;
            end
            ST_YZ_M: begin
                w_ma = r_y;
                w_mb = r_zi;
            end
            ST_XY_M: begin
                w_ma = r_x;
                w_mb = r_y;
            end
            ST_XX_M, ST_SX_M: begin
                w_ma = r_x;
                w_mb = r_x;
            end
            ST_YY_M, ST_SY_M: begin
                w_ma = r_y;
                w_mb = r_y;
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_pm  = w_ma * w_mb;
    // round half up, floor shift
    assign w_mw  = ($signed({r_prod[63], r_prod}) + HALF) >>> FRAC_BITS;
    assign w_acc = r_acc + 66'(w_mw);

    // requests to the divide / sqrt unit
    always_comb begin
        w_req.start = 1'b0;
        w_req.op    = prr_pkg::OP_DIV;
        w_req.num   = '0;
        w_req.den   = '0;
        w_req.rad   = r_ss;
        unique case (r_state)
            ST_DIV_X: begin
                w_req.num = 34'(r_cam[0]);
                w_req.den = r_cam[2];
            end
            ST_DIV_Y: begin
                w_req.num = 34'(r_cam[1]);
                w_req.den = r_cam[2];
            end
            ST_DIV_IX: begin
                w_req.num = 34'(r_obs_u) - {3'b000, r_cx};
                w_req.den = {1'b0, r_fx};
            end
            ST_DIV_IY: begin
                w_req.num = 34'(r_obs_v) - {3'b000, r_cy};
                w_req.den = {1'b0, r_fy};
            end
            ST_DIV_ZI: begin
                w_req.num = ONE_N;
                w_req.den = r_cam[2];
            end
            ST_SQRT: begin
                w_req.op = prr_pkg::OP_SQRT;
            end
            ST_DIV_BX: begin
                w_req.num = 34'(r_x);
                w_req.den = r_n;
            end
            ST_DIV_BY: begin
                w_req.num = 34'(r_y);
                w_req.den = r_n;
            end
            ST_DIV_BZ: begin
                w_req.num = ONE_N;
                w_req.den = r_n;
            end
            default: begin
                w_req.num = '0;
            end
        endcase
        case (r_state) inside
            ST_DIV_X, ST_DIV_Y, ST_DIV_IX, ST_DIV_IY, ST_DIV_ZI, ST_SQRT,
            ST_DIV_BX, ST_DIV_BY, ST_DIV_BZ: begin
                w_req.start = !r_wait;
            end
            default: begin
                w_req.start = 1'b0;
            end
        endcase
    end

    prr_iter #(
        .FRAC_BITS (FRAC_BITS)
    ) u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // result word assembly
    always_comb begin
        w_ld    = 1'b0;
        w_lpart = prr_pkg::PART_PIXEL;
        w_la    = r_up;
        w_lb    = r_vp;
        w_lc    = sat32(66'(r_obs_u) - 66'(r_up));
        w_ld_v  = sat32(66'(r_obs_v) - 66'(r_vp));
        unique case (r_state)
            ST_OUT0: begin
                w_ld = w_ofree;
            end
            ST_OUT1: begin
                w_ld    = w_ofree;
                w_lpart = prr_pkg::PART_IDEAL;
                w_la    = r_x;
                w_lb    = r_y;
                w_lc    = sat32(66'(r_ix) - 66'(r_x));
                w_ld_v  = sat32(66'(r_iy) - 66'(r_y));
            end
            ST_OUT2: begin
                w_ld    = w_ofree;
                w_lpart = prr_pkg::PART_JAC_A;
                w_la    = r_zi;
                w_lb    = r_xz;
                w_lc    = r_yz;
                w_ld_v  = r_xy;
            end
            ST_OUT3: begin
                w_ld    = w_ofree;
                w_lpart = prr_pkg::PART_JAC_B;
                w_la    = r_pa;
                w_lb    = r_pb;
                w_lc    = '0;
                w_ld_v  = '0;
            end
            ST_OUT4: begin
                w_ld    = w_ofree;
                w_lpart = prr_pkg::PART_BEARING;
                w_la    = r_bx;
                w_lb    = r_by;
                w_lc    = r_bz;
                w_ld_v  = r_cam[2];
            end
            default: begin
                w_ld = 1'b0;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (w_obs_go) n_state = ST_ROT_M;
            ST_ROT_M:  n_state = ST_ROT_A;
            ST_ROT_A:  n_state = (r_ri == 2'd2 && r_rj == 2'd2) ? ST_CHK : ST_ROT_M;
            ST_CHK:    n_state = (r_cam[2] > 32'sd0) ? ST_DIV_X : ST_IDLE;
            ST_DIV_X:  if (r_wait && w_rsp.done) n_state = ST_DIV_Y;
            ST_DIV_Y:  if (r_wait && w_rsp.done) n_state = ST_UP_M;
            ST_UP_M:   n_state = ST_UP_A;
            ST_UP_A:   n_state = ST_VP_M;
            ST_VP_M:   n_state = ST_VP_A;
            ST_VP_A:   n_state = ST_OUT0;
            ST_OUT0:   if (w_ofree) n_state = r_ideal ? ST_DIV_IX : ST_SX_M;
            ST_DIV_IX: if (r_wait && w_rsp.done) n_state = ST_DIV_IY;
            ST_DIV_IY: if (r_wait && w_rsp.done) n_state = ST_DIV_ZI;
            ST_DIV_ZI: if (r_wait && w_rsp.done) n_state = ST_OUT1;
            ST_OUT1:   if (w_ofree) n_state = ST_XZ_M;
            ST_XZ_M:   n_state = ST_XZ_A;
            ST_XZ_A:   n_state = ST_YZ_M;
            ST_YZ_M:   n_state = ST_YZ_A;
            ST_YZ_A:   n_state = ST_XY_M;
            ST_XY_M:   n_state = ST_XY_A;
            ST_XY_A:   n_state = ST_OUT2;
            ST_OUT2:   if (w_ofree) n_state = ST_XX_M;
            ST_XX_M:   n_state = ST_XX_A;
            ST_XX_A:   n_state = ST_YY_M;
            ST_YY_M:   n_state = ST_YY_A;
            ST_YY_A:   n_state = ST_OUT3;
            ST_OUT3:   if (w_ofree) n_state = ST_SX_M;
            ST_SX_M:   n_state = ST_SX_A;
            ST_SX_A:   n_state = ST_SY_M;
            ST_SY_M:   n_state = ST_SY_A;
            ST_SY_A:   n_state = ST_SQRT;
            ST_SQRT:   if (r_wait && w_rsp.done) n_state = ST_DIV_BX;
            ST_DIV_BX: if (r_wait && w_rsp.done) n_state = ST_DIV_BY;
            ST_DIV_BY: if (r_wait && w_rsp.done) n_state = ST_DIV_BZ;
            ST_DIV_BZ: if (r_wait && w_rsp.done) n_state = ST_OUT4;
            ST_OUT4:   if (w_ofree) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_wait  <= 1'b0;
            r_ov    <= 1'b0;
            r_fx    <= prr_pkg::FOCAL_X_RST;
            r_fy    <= prr_pkg::FOCAL_Y_RST;
            r_cx    <= prr_pkg::CENTER_X_RST;
            r_cy    <= prr_pkg::CENTER_Y_RST;
            r_ideal <= prr_pkg::IDEAL_MODE_RST;
            for (int k = 0; k < 9; k++) r_rot[k] <= '0;
            for (int k = 0; k < 3; k++) r_pos[k] <= '0;
        end else begin
            r_state <= n_state;
            if (w_req.start) begin
                r_wait <= 1'b1;
            end else if (w_rsp.done) begin
                r_wait <= 1'b0;
            end
            if (w_ld) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    prr_pkg::REG_FOCAL_X:    r_fx    <= i_cfg.data[30:0];
                    prr_pkg::REG_FOCAL_Y:    r_fy    <= i_cfg.data[30:0];
                    prr_pkg::REG_CENTER_X:   r_cx    <= i_cfg.data[30:0];
                    prr_pkg::REG_CENTER_Y:   r_cy    <= i_cfg.data[30:0];
                    prr_pkg::REG_IDEAL_MODE: r_ideal <= i_cfg.data[0];
                    default: ;
                endcase
            end
            // pose words beyond slot eleven are dropped
            if (w_pose_go) begin
                if (i_obs.pose_index < 4'd9) begin
                    r_rot[i_obs.pose_index] <= i_obs.pose_value;
                end else if (i_obs.pose_index < 4'd12) begin
                    r_pos[2'(i_obs.pose_index - 4'd9)] <= i_obs.pose_value;
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= w_pm;
        if (w_obs_go) begin
            r_id    <= i_obs.lm_ident;
            r_obs_u <= i_obs.observed_u;
            r_obs_v <= i_obs.observed_v;
            r_d[0]  <= sat32(66'(i_obs.landmark_x) - 66'(r_pos[0]));
            r_d[1]  <= sat32(66'(i_obs.landmark_y) - 66'(r_pos[1]));
            r_d[2]  <= sat32(66'(i_obs.landmark_z) - 66'(r_pos[2]));
            r_acc   <= '0;
            r_ri    <= '0;
            r_rj    <= '0;
        end
        // camera axis i = sum over j of R[j][i] * d[j]
        if (r_state == ST_ROT_A) begin
            if (r_rj == 2'd2) begin
                r_cam[r_ri] <= sat32(w_acc);
                r_acc       <= '0;
                r_rj        <= '0;
                r_ri        <= r_ri + 2'd1;
            end else begin
                r_acc <= w_acc;
                r_rj  <= r_rj + 2'd1;
            end
        end
        if (r_wait && w_rsp.done) begin
            case (r_state)
                ST_DIV_X:  r_x  <= $signed(w_rsp.value);
                ST_DIV_Y:  r_y  <= $signed(w_rsp.value);
                ST_DIV_IX: r_ix <= $signed(w_rsp.value);
                ST_DIV_IY: r_iy <= $signed(w_rsp.value);
                ST_DIV_ZI: r_zi <= $signed(w_rsp.value);
                ST_SQRT:   r_n  <= w_rsp.value;
                ST_DIV_BX: r_bx <= $signed(w_rsp.value);
                ST_DIV_BY: r_by <= $signed(w_rsp.value);
                ST_DIV_BZ: r_bz <= $signed(w_rsp.value);
                default: ;
            endcase
        end
        case (r_state)
            ST_UP_A: r_up <= sat32(66'(w_mw) + 66'({1'b0, r_cx}));
            ST_VP_A: r_vp <= sat32(66'(w_mw) + 66'({1'b0, r_cy}));
            ST_XZ_A: r_xz <= sat32(66'(w_mw));
            ST_YZ_A: r_yz <= sat32(66'(w_mw));
            ST_XY_A: r_xy <= sat32(66'(w_mw));
            ST_XX_A: r_pa <= sat32(ONE_W + 66'(w_mw));
            ST_YY_A: r_pb <= sat32(ONE_W + 66'(w_mw));
            ST_SX_A: r_ss <= r_prod;
            ST_SY_A: r_ss <= r_ss + r_prod + ONE_SQ;
            default: ;
        endcase
        if (w_ld) begin
            r_olm   <= r_id;
            r_opart <= w_lpart;
            r_oa    <= w_la;
            r_ob    <= w_lb;
            r_oc    <= w_lc;
            r_od    <= w_ld_v;
            r_olast <= (r_state == ST_OUT4);
        end
    end

    assign o_res.valid           = r_ov;
    assign o_res.result_landmark = r_olm;
    assign o_res.part            = r_opart;
    assign o_res.value_a         = r_oa;
    assign o_res.value_b         = r_ob;
    assign o_res.value_c         = r_oc;
    assign o_res.value_d         = r_od;
    assign o_res.last            = r_olast;

    `PRR_ASSERT(a_last_bearing, r_ov && r_olast |-> r_opart == prr_pkg::PART_BEARING)
    `PRR_ASSERT_NEVER(a_start_free, w_req.start && w_rsp.busy)
    `PRR_ASSERT(a_idle_quiet, r_state == ST_IDLE |-> !w_rsp.busy)
    `PRR_ASSERT(a_obs_starts, w_obs_go |=> r_state == ST_ROT_M)

endmodule

FILE: src/prr_iter.sv
// ============================================================================
// prr_iter
// Shared iterative unit: saturating fixed point divide, 64-bit floor sqrt.
// ============================================================================
module prr_iter #(
    parameter int FRAC_BITS = prr_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  prr_pkg::t_iter_req i_req,
    output prr_pkg::t_iter_rsp o_rsp
);
    localparam int DW = 33 + FRAC_BITS;
    localparam int HW = DW - 32;

    logic        r_busy, r_done, r_op, r_neg;
    logic [4:0]  r_cnt;
    logic [34:0] r_rem;
    logic [63:0] r_sh;
    logic [31:0] r_acc, r_den, r_res;

    logic [33:0]   w_nnum;
    logic [32:0]   w_mag;
    logic [DW-1:0] w_dvd;
    logic [HW-1:0] w_hi;
    logic          w_ovf;
    logic [32:0]   w_dt, w_dsub;
    logic          w_dge;
    logic [31:0]   w_q, w_dres;
    logic [34:0]   w_st, w_tr;
    logic          w_sge;
    logic [31:0]   w_root;

    // start: magnitude of numerator, pre-shifted; quotient >= 2^32 saturates
    assign w_nnum = -i_req.num;
    assign w_mag  = i_req.num[33] ? w_nnum[32:0] : i_req.num[32:0];
    assign w_dvd  = DW'(w_mag) << FRAC_BITS;
    assign w_hi   = w_dvd[DW-1:32];
    assign w_ovf  = 32'(w_hi) >= i_req.den;

    // restoring divide step
    assign w_dt   = {r_rem[31:0], r_sh[63]};
    assign w_dge  = w_dt >= {1'b0, r_den};
    assign w_dsub = w_dt - {1'b0, r_den};
    assign w_q    = {r_acc[30:0], w_dge};

    always_comb begin
        if (r_neg) begin
            w_dres = (w_q > prr_pkg::SAT_MIN) ? prr_pkg::SAT_MIN : -w_q;
        end else begin
            w_dres = w_q[31] ? prr_pkg::SAT_MAX : w_q;
        end
    end

    // digit-by-digit sqrt step, two radicand bits per step
    assign w_st   = {r_rem[32:0], r_sh[63:62]};
    assign w_tr   = {1'b0, r_acc, 2'b01};
    assign w_sge  = w_st >= w_tr;
    assign w_root = {r_acc[30:0], w_sge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_op == prr_pkg::OP_SQRT) begin
                    r_rem <= w_sge ? (w_st - w_tr) : w_st;
                    r_sh  <= {r_sh[61:0], 2'b00};
                    r_acc <= w_root;
                    r_res <= w_root;
                end else begin
                    r_rem <= 35'(w_dge ? w_dsub : w_dt);
                    r_sh  <= {r_sh[62:0], 1'b0};
                    r_acc <= w_q;
                    r_res <= w_dres;
                end
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (i_req.start) begin
                r_op  <= i_req.op;
                r_cnt <= '0;
                r_acc <= '0;
                r_den <= i_req.den;
                r_neg <= i_req.num[33];
                if (i_req.op == prr_pkg::OP_SQRT) begin
                    r_rem  <= '0;
                    r_sh   <= i_req.rad;
                    r_busy <= 1'b1;
                end else if (w_ovf) begin
                    r_res  <= i_req.num[33] ? prr_pkg::SAT_MIN : prr_pkg::SAT_MAX;
                    r_done <= 1'b1;
                end else begin
                    r_rem  <= 35'(w_hi);
                    r_sh   <= {w_dvd[31:0], 32'd0};
                    r_busy <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.busy  = r_busy;
    assign o_rsp.value = r_res;

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// tb - testbench for pinhole_reprojection_residual
// Drives pose words and observations with random gaps and output stalls,
// predicts every result word in a scoreboard and compares field by field.
// ============================================================================

typedef struct {
    logic               func;
    logic [3:0]         pose_index;
    logic signed [31:0] pose_value;
    logic [15:0]        lm_ident;
    logic               landmark_found;
    logic signed [31:0] landmark_x;
    logic signed [31:0] landmark_y;
    logic signed [31:0] landmark_z;
    logic signed [31:0] observed_u;
    logic signed [31:0] observed_v;
} t_obs_word;

typedef struct {
    logic [15:0] landmark;
    logic [2:0]  part;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic        last;
} t_res_word;

class t_residual_scoreboard;
    localparam int  FB  = prr_pkg::FRAC_BITS_DEF;
    localparam longint ONE = longint'(1) << FB;
    localparam longint S32_MAX = 64'sh7fff_ffff;
    localparam longint S32_MIN = -64'sh8000_0000;

    longint     rotation[9];
    longint     position[3];
    longint     fx, fy, cx, cy;
    bit         ideal;
    t_res_word  pending_words[$];
    int         mismatches;

    function new();
        foreach (rotation[i]) rotation[i] = 0;
        foreach (position[i]) position[i] = 0;
        fx = longint'(prr_pkg::FOCAL_X_RST);
        fy = longint'(prr_pkg::FOCAL_Y_RST);
        cx = longint'(prr_pkg::CENTER_X_RST);
        cy = longint'(prr_pkg::CENTER_Y_RST);
        ideal = prr_pkg::IDEAL_MODE_RST;
        mismatches = 0;
    endfunction

    function longint sat(longint v);
        if (v > S32_MAX) return S32_MAX;
        if (v < S32_MIN) return S32_MIN;
        return v;
    endfunction

    // rounded product, arithmetic shift floors so +half rounds half up
    function longint qmul(longint a, longint b);
        return (a * b + (longint'(1) << (FB - 1))) >>> FB;
    endfunction

    function longint qdiv(longint num, longint den);
        if (den == 0) return (num >= 0) ? S32_MAX : S32_MIN;
        return sat((num * ONE) / den);
    endfunction

    function longint unsigned root(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function void push(logic [15:0] id, logic [2:0] part, longint a, longint b,
                       longint c, longint d, logic last);
        t_res_word r;
        r.landmark = id;
        r.part = part;
        r.a = a[31:0];
        r.b = b[31:0];
        r.c = c[31:0];
        r.d = d[31:0];
        r.last = last;
        pending_words = {pending_words, r};
    endfunction

    function void set_reg(logic [prr_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
        case (idx)
            prr_pkg::REG_FOCAL_X:    fx = longint'(data[30:0]);
            prr_pkg::REG_FOCAL_Y:    fy = longint'(data[30:0]);
            prr_pkg::REG_CENTER_X:   cx = longint'(data[30:0]);
            prr_pkg::REG_CENTER_Y:   cy = longint'(data[30:0]);
            prr_pkg::REG_IDEAL_MODE: ideal = data[0];
            default: ;
        endcase
    endfunction

    function void note_word(t_obs_word w);
        longint dl[3], cam[3], lm[3];
        longint acc, x, y, z, up, vp, ou, ov, ix, iy, zinv;
        longint unsigned ss, n;
        if (!w.func) begin
            if (w.pose_index < 9) rotation[w.pose_index] = longint'(w.pose_value);
            else if (w.pose_index < 12)
                position[w.pose_index - 9] = longint'(w.pose_value);
            return;
        end
        if (!w.landmark_found) return;
        lm[0] = longint'(w.landmark_x);
        lm[1] = longint'(w.landmark_y);
        lm[2] = longint'(w.landmark_z);
        for (int j = 0; j < 3; j++) dl[j] = sat(lm[j] - position[j]);
        // camera frame = R^T * (landmark - position)
        for (int i = 0; i < 3; i++) begin
            acc = 0;
            for (int j = 0; j < 3; j++) acc += qmul(rotation[3*j+i], dl[j]);
            cam[i] = sat(acc);
        end
        z = cam[2];
        if (z <= 0) return;
        ou = longint'(w.observed_u);
        ov = longint'(w.observed_v);
        x = qdiv(cam[0], z);
        y = qdiv(cam[1], z);
        up = sat(qmul(fx, x) + cx);
        vp = sat(qmul(fy, y) + cy);
        push(w.lm_ident, prr_pkg::PART_PIXEL, up, vp, sat(ou - up), sat(ov - vp), 1'b0);
        if (ideal) begin
            ix = qdiv(ou - cx, fx);
            iy = qdiv(ov - cy, fy);
            zinv = qdiv(ONE, z);
            push(w.lm_ident, prr_pkg::PART_IDEAL, x, y, sat(ix - x), sat(iy - y), 1'b0);
            push(w.lm_ident, prr_pkg::PART_JAC_A, zinv, sat(qmul(x, zinv)),
                 sat(qmul(y, zinv)), sat(qmul(x, y)), 1'b0);
            push(w.lm_ident, prr_pkg::PART_JAC_B, sat(ONE + qmul(x, x)),
                 sat(ONE + qmul(y, y)), 0, 0, 1'b0);
        end
        ss = longint'(x * x) + longint'(y * y) + longint'(ONE * ONE);
        n = root(ss);
        push(w.lm_ident, prr_pkg::PART_BEARING, qdiv(x, longint'(n)),
             qdiv(y, longint'(n)), qdiv(ONE, longint'(n)), z, 1'b1);
    endfunction

    function void check_result(t_res_word got);
        t_res_word want;
        if (pending_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result word: id %h part %0d", got.landmark, got.part);
            return;
        end
        want = pending_words.pop_front();
        if (got.landmark !== want.landmark || got.part !== want.part ||
            got.a !== want.a || got.b !== want.b || got.c !== want.c ||
            got.d !== want.d || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch exp: id %h part %0d a %h b %h c %h d %h last %b",
                         want.landmark, want.part, want.a, want.b, want.c, want.d,
                         want.last);
                $display("         got: id %h part %0d a %h b %h c %h d %h last %b",
                         got.landmark, got.part, got.a, got.b, got.c, got.d, got.last);
            end
        end
    endfunction
endclass

module tb;
    localparam logic FUNC_POSE = 1'b0;
    localparam logic FUNC_OBS  = 1'b1;
    localparam logic [prr_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;
    localparam int   ONE_Q     = 1 << prr_pkg::FRAC_BITS_DEF;
    // long enough for the worst observation, also one that yields nothing
    localparam int   DRAIN_CYCLES = 600;

    logic i_clk;
    logic i_rst_n;

    prr_obs_if obs ();
    prr_res_if res ();
    prr_cfg_if cfg ();

    t_residual_scoreboard sb;
    bit calm;    // when set, neither side idles

    pinhole_reprojection_residual dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_obs  (obs.sink),
        .o_res  (res.source),
        .i_cfg  (cfg.sink)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    // result monitor: values read here are those sampled at the edge
    always @(posedge i_clk) begin
        t_res_word r;
        if (i_rst_n && res.valid && res.ready) begin
            r.landmark = res.result_landmark;
            r.part = res.part;
            r.a = res.value_a;
            r.b = res.value_b;
            r.c = res.value_c;
            r.d = res.value_d;
            r.last = res.last;
            sb.check_result(r);
        end
    end

    // receiver stalls
    initial begin
        int g;
        res.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            res.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            g = pick_gap();
            if (g > 0) begin
                res.ready <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
        end
    end

    // starts in the current step; leaves valid high when no gap follows
    task automatic send_word(t_obs_word w);
        int g;
        obs.valid <= 1'b1;
        obs.func <= w.func;
        obs.pose_index <= w.pose_index;
        obs.pose_value <= w.pose_value;
        obs.lm_ident <= w.lm_ident;
        obs.landmark_found <= w.landmark_found;
        obs.landmark_x <= w.landmark_x;
        obs.landmark_y <= w.landmark_y;
        obs.landmark_z <= w.landmark_z;
        obs.observed_u <= w.observed_u;
        obs.observed_v <= w.observed_v;
        do @(posedge i_clk); while (!obs.ready);
        sb.note_word(w);
        g = pick_gap();
        if (g > 0) begin
            obs.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic pose_word(logic [3:0] idx, logic signed [31:0] val);
        t_obs_word w;
        w.func = FUNC_POSE;
        w.pose_index = idx;
        w.pose_value = val;
        w.lm_ident = 16'($urandom);
        w.landmark_found = 1'($urandom);
        w.landmark_x = $urandom;
        w.landmark_y = $urandom;
        w.landmark_z = $urandom;
        w.observed_u = $urandom;
        w.observed_v = $urandom;
        send_word(w);
    endtask

    task automatic observe(logic found, logic signed [31:0] lx, logic signed [31:0] ly,
                           logic signed [31:0] lz, logic signed [31:0] ou,
                           logic signed [31:0] ov);
        t_obs_word w;
        w.func = FUNC_OBS;
        w.pose_index = 4'($urandom);
        w.pose_value = $urandom;
        w.lm_ident = 16'($urandom);
        w.landmark_found = found;
        w.landmark_x = lx;
        w.landmark_y = ly;
        w.landmark_z = lz;
        w.observed_u = ou;
        w.observed_v = ov;
        send_word(w);
    endtask

    // sender holds off until every word is back, then lets the block settle
    task automatic drain();
        obs.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // valid drops between writes, keeping writes in separate steps
    task automatic write_reg(logic [prr_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= data;
        do @(posedge i_clk); while (!cfg.ready);
        sb.set_reg(idx, data);
        cfg.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_camera(logic [31:0] fxv, logic [31:0] fyv, logic [31:0] cxv,
                              logic [31:0] cyv, logic [31:0] idl);
        drain();
        write_reg(prr_pkg::REG_FOCAL_X, fxv);
        write_reg(prr_pkg::REG_FOCAL_Y, fyv);
        write_reg(prr_pkg::REG_CENTER_X, cxv);
        write_reg(prr_pkg::REG_CENTER_Y, cyv);
        write_reg(prr_pkg::REG_IDEAL_MODE, idl);
    endtask

    // rotation entries in [-1, 1]; identity half the time
    task automatic load_pose();
        bit eye;
        eye = 1'($urandom_range(0, 1));
        for (int i = 0; i < 9; i++)
            pose_word(4'(i), eye ? ((i % 4 == 0) ? ONE_Q : 0)
                                 : $urandom_range(0, 2 * ONE_Q) - ONE_Q);
        for (int i = 9; i < 12; i++)
            pose_word(4'(i), $urandom_range(0, 40 * ONE_Q) - 20 * ONE_Q);
    endtask

    // landmark near the camera, depth of either sign
    task automatic plausible_obs();
        int lx, ly, lz;
        lx = $urandom_range(0, 60 * ONE_Q) - 30 * ONE_Q;
        ly = $urandom_range(0, 60 * ONE_Q) - 30 * ONE_Q;
        lz = $urandom_range(0, 60 * ONE_Q) - 30 * ONE_Q;
        observe(($urandom_range(0, 9) != 0), lx, ly, lz,
                $urandom_range(0, 1280 * ONE_Q), $urandom_range(0, 960 * ONE_Q));
    endtask

    task automatic random_run(int count);
        int r;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 70) plausible_obs();
            else if (r < 78) load_pose();
            else if (r < 88) pose_word(4'($urandom), $urandom);
            else observe(1'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom);
        end
    endtask

    initial begin
        sb = new();
        calm = 1'b0;
        i_rst_n <= 1'b0;
        obs.valid <= 1'b0;
        obs.func <= FUNC_POSE;
        obs.pose_index <= '0;
        obs.pose_value <= '0;
        obs.lm_ident <= '0;
        obs.landmark_found <= 1'b0;
        obs.landmark_x <= '0;
        obs.landmark_y <= '0;
        obs.landmark_z <= '0;
        obs.observed_u <= '0;
        obs.observed_v <= '0;
        cfg.valid <= 1'b0;
        cfg.index <= '0;
        cfg.data <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed ---
        // zero pose after reset: depth zero, nothing comes back
        observe(1'b1, ONE_Q, ONE_Q, ONE_Q, 0, 0);
        // identity rotation, camera at origin
        load_pose();
        for (int i = 0; i < 12; i++) pose_word(4'(i), (i < 9 && i % 4 == 0) ? ONE_Q : 0);
        pose_word(4'd12, 32'h7fff_ffff);    // out of range slots: ignored
        pose_word(4'd15, 32'h8000_0000);
        observe(1'b1, 0, 0, ONE_Q, 0, 0);
        observe(1'b0, 0, 0, ONE_Q, 0, 0);                   // not found
        observe(1'b1, ONE_Q, ONE_Q, -ONE_Q, 0, 0);          // behind camera
        observe(1'b1, 32'h7fff_ffff, 32'h8000_0000, 1, 32'h7fff_ffff, 32'h8000_0000);
        observe(1'b1, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                32'h8000_0000, 32'h7fff_ffff);
        observe(1'b1, -ONE_Q, ONE_Q / 2, 4 * ONE_Q, 32'hffff_ffff, 1);
        // extreme pose words saturate the difference and the rotation sums
        pose_word(4'd8, 32'h7fff_ffff);
        pose_word(4'd11, 32'h8000_0000);
        observe(1'b1, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0);

        // zero focal lengths (written with the masked top bit set), ideal off
        set_camera(32'h8000_0000, 32'h8000_0000, 32'hffff_ffff, 32'h7fff_ffff, 32'h0);
        write_reg(REG_SPARE, 32'hffff_ffff);     // unused index
        load_pose();
        observe(1'b1, 0, 0, 2 * ONE_Q, 5 * ONE_Q, -5 * ONE_Q);
        set_camera(32'h8000_0000, 32'h0, 32'h0, 32'h0, 32'h1);
        observe(1'b1, ONE_Q, -ONE_Q, 3 * ONE_Q, -ONE_Q, ONE_Q);
        plausible_obs();

        // --- random phases over several camera settings ---
        set_camera($urandom_range(1, 1000 * ONE_Q), $urandom_range(1, 1000 * ONE_Q),
                   $urandom_range(0, 700 * ONE_Q), $urandom_range(0, 500 * ONE_Q), 1);
        load_pose();
        random_run(10);
        set_camera(32'd1, 32'd1, 32'd0, 32'd0, 32'h0);
        calm = 1'b1;
        load_pose();
        random_run(8);
        calm = 1'b0;
        set_camera(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h1);
        load_pose();
        random_run(8);
        set_camera($urandom, $urandom, $urandom, $urandom, $urandom);
        load_pose();
        random_run(12);
        set_camera(32'(prr_pkg::FOCAL_X_RST), 32'(prr_pkg::FOCAL_Y_RST),
                   32'(prr_pkg::CENTER_X_RST), 32'(prr_pkg::CENTER_Y_RST), 32'h1);
        load_pose();
        random_run(10);

        drain();
        if (sb.mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
